@@ src/rfs_pkg.sv @@
// ----------------------------------------------------------------------------
// rfs_pkg: shared types and constants of the roulette fitness selector
// Field widths, opcodes, the divider handshake and the microcode ROM that
// steps the selector through clear, append and select words.
// ----------------------------------------------------------------------------
package rfs_pkg;

   // sizes of the fitness store and of the word fields
   localparam int POP_DEPTH = 64;
   localparam int ADDR_W    = $clog2(POP_DEPTH);
   localparam int COUNT_W   = $clog2(POP_DEPTH + 1);
   localparam int FIT_W     = 16;
   localparam int FRAC_W    = 16;
   localparam int TOTAL_W   = 22;
   localparam int TARGET_W  = TOTAL_W + FRAC_W;
   localparam int DIV_CNT_W = $clog2(TOTAL_W + 1);
   localparam int STEP_W    = 4;

   localparam logic [FIT_W-1:0] LOWEST_RESET = '1;

   // request opcodes
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_SELECT = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // datapath action driven by one control word
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_WALK_INIT,
      ACT_WALK_STEP,
      ACT_CLEAR,
      ACT_APPEND,
      ACT_DIV_START,
      ACT_AVG_LOAD,
      ACT_LOAD_RSP
   } act_type;

   // conditions tested by the sequencer
   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_ACCEPT,
      COND_IS_CLEAR,
      COND_IS_APPEND,
      COND_NO_WALK,
      COND_NO_HIT,
      COND_DIV_BUSY,
      COND_RSP_BLOCKED
   } cond_type;

   // one control word: hold on hold_cond, else jump on jump_cond, else step on
   typedef struct packed {
      logic              take;
      act_type           act;
      cond_type          hold_cond;
      cond_type          jump_cond;
      logic [STEP_W-1:0] target;
   } uword_type;

   // program addresses
   localparam logic [STEP_W-1:0] STEP_WAIT      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DISP_CLR  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DISP_APP  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DISP_SEL  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_SEL_INIT  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_WALK      = 4'd5;
   localparam logic [STEP_W-1:0] STEP_CLR       = 4'd6;
   localparam logic [STEP_W-1:0] STEP_APP       = 4'd7;
   localparam logic [STEP_W-1:0] STEP_DIV_START = 4'd8;
   localparam logic [STEP_W-1:0] STEP_DIV_WAIT  = 4'd9;
   localparam logic [STEP_W-1:0] STEP_OUT       = 4'd10;

   // divider handshake
   typedef struct packed {
      logic               start;
      logic [TOTAL_W-1:0] dividend;
      logic [COUNT_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic               busy;
      logic [TOTAL_W-1:0] quotient;
   } div_sts_type;

   // microcode rom
   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      w = '{take: 1'b0, act: ACT_NONE, hold_cond: COND_NEVER,
            jump_cond: COND_ALWAYS, target: STEP_WAIT};
      unique case (step)
         STEP_WAIT: begin
            w.take      = 1'b1;
            w.hold_cond = COND_NO_ACCEPT;
            w.jump_cond = COND_NEVER;
         end
         STEP_DISP_CLR: begin
            w.jump_cond = COND_IS_CLEAR;
            w.target    = STEP_CLR;
         end
         STEP_DISP_APP: begin
            w.jump_cond = COND_IS_APPEND;
            w.target    = STEP_APP;
         end
         STEP_DISP_SEL: begin
            w.jump_cond = COND_NO_WALK;
            w.target    = STEP_OUT;
         end
         STEP_SEL_INIT: begin
            w.act       = ACT_WALK_INIT;
            w.jump_cond = COND_NEVER;
         end
         STEP_WALK: begin
            w.act       = ACT_WALK_STEP;
            w.hold_cond = COND_NO_HIT;
            w.target    = STEP_OUT;
         end
         STEP_CLR: begin
            w.act    = ACT_CLEAR;
            w.target = STEP_OUT;
         end
         STEP_APP: begin
            w.act       = ACT_APPEND;
            w.jump_cond = COND_NEVER;
         end
         STEP_DIV_START: begin
            w.act       = ACT_DIV_START;
            w.jump_cond = COND_NEVER;
         end
         STEP_DIV_WAIT: begin
            w.act       = ACT_AVG_LOAD;
            w.hold_cond = COND_DIV_BUSY;
            w.jump_cond = COND_NEVER;
         end
         STEP_OUT: begin
            w.act       = ACT_LOAD_RSP;
            w.hold_cond = COND_RSP_BLOCKED;
            w.target    = STEP_WAIT;
         end
         default: begin
            w.target = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

@@ src/rfs_divider.sv @@
// ----------------------------------------------------------------------------
// rfs_divider: restoring divider for the average fitness
// Produces one quotient bit a cycle, most significant first; busy drops
// once every dividend bit has been shifted through.
// ----------------------------------------------------------------------------
module rfs_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rfs_pkg::div_ctl_type div_ctl,
   output rfs_pkg::div_sts_type div_sts
);

   logic                            busy_ff, busy_in;
   logic [rfs_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [rfs_pkg::COUNT_W-1:0]     rem_ff, rem_in;
   logic [rfs_pkg::TOTAL_W-1:0]     quot_ff, quot_in;
   logic [rfs_pkg::COUNT_W-1:0]     divisor_ff, divisor_in;
   logic [rfs_pkg::COUNT_W:0]       trial;
   logic [rfs_pkg::COUNT_W:0]       diff;
   logic                            ge;

   // one trial subtraction
   always_comb begin
      trial = {rem_ff, quot_ff[rfs_pkg::TOTAL_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      ge    = (trial >= {1'b0, divisor_ff});
   end

   // next state of the divider
   always_comb begin
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (div_ctl.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quot_in    = div_ctl.dividend;
         divisor_in = div_ctl.divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[rfs_pkg::COUNT_W-1:0] : trial[rfs_pkg::COUNT_W-1:0];
         quot_in = {quot_ff[rfs_pkg::TOTAL_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == rfs_pkg::DIV_CNT_W'(rfs_pkg::TOTAL_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign div_sts.busy     = busy_ff;
   assign div_sts.quotient = quot_ff;

endmodule

@@ src/roulette_fitness_selector.sv @@
// ----------------------------------------------------------------------------
// roulette_fitness_selector: fitness-proportionate selection engine
// A microcoded sequencer steps a store of fitness words, running statistics,
// a roulette walk over the store and a serial divider for the average.
// ----------------------------------------------------------------------------
// From request accept to response valid: a clear runs the clear step, an append
// the append, divider start and divider wait steps, a select the walk set-up and
// the walk up to the chosen entry, and a no-op or empty select goes straight out;
// the walk reads one stored word a cycle through the store's single read port.
// One request is in work at a time; the next is taken while a response waits.
// Synchronous reset empties the generation; the store itself is not cleared.
module roulette_fitness_selector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [rfs_pkg::FIT_W-1:0]     req_fitness_value,
   input  logic [rfs_pkg::FRAC_W-1:0]    req_random_fraction,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rfs_pkg::ADDR_W-1:0]    rsp_chosen_index,
   output logic                          rsp_found,
   output logic [rfs_pkg::TOTAL_W-1:0]   rsp_total_fitness,
   output logic [rfs_pkg::FIT_W-1:0]     rsp_best_fitness,
   output logic [rfs_pkg::ADDR_W-1:0]    rsp_best_index,
   output logic [rfs_pkg::FIT_W-1:0]     rsp_worst_fitness,
   output logic [rfs_pkg::FIT_W-1:0]     rsp_average_fitness,
   output logic [rfs_pkg::COUNT_W-1:0]   rsp_stored_count
);

   // sequencer
   logic [rfs_pkg::STEP_W-1:0]   step_ff, step_in;
   rfs_pkg::uword_type           uw;

   // latched request word
   rfs_pkg::op_type              op_ff;
   logic [rfs_pkg::FIT_W-1:0]    fit_ff;
   logic [rfs_pkg::FRAC_W-1:0]   frac_ff;

   // generation statistics
   logic [rfs_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [rfs_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [rfs_pkg::FIT_W-1:0]    best_ff, best_in;
   logic [rfs_pkg::ADDR_W-1:0]   best_idx_ff, best_idx_in;
   logic [rfs_pkg::FIT_W-1:0]    worst_ff, worst_in;
   logic [rfs_pkg::FIT_W-1:0]    avg_ff, avg_in;

   // roulette walk
   logic [rfs_pkg::TARGET_W-1:0] target_ff;
   logic [rfs_pkg::TARGET_W-1:0] product;
   logic [rfs_pkg::TOTAL_W-1:0]  sum_ff, sum_next;
   logic [rfs_pkg::ADDR_W-1:0]   idx_ff;
   logic [rfs_pkg::ADDR_W-1:0]   rd_addr;
   logic [rfs_pkg::FIT_W-1:0]    rd_ff;
   logic                         hit;
   logic [rfs_pkg::ADDR_W-1:0]   chosen_ff;
   logic                         found_ff;

   // fitness store
   logic [rfs_pkg::FIT_W-1:0]    store [rfs_pkg::POP_DEPTH];
   logic                         store_we;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_blocked;
   logic                         rsp_load;
   logic [rfs_pkg::ADDR_W-1:0]   rsp_chosen_ff;
   logic                         rsp_found_ff;
   logic [rfs_pkg::TOTAL_W-1:0]  rsp_total_ff;
   logic [rfs_pkg::FIT_W-1:0]    rsp_best_ff;
   logic [rfs_pkg::ADDR_W-1:0]   rsp_best_idx_ff;
   logic [rfs_pkg::FIT_W-1:0]    rsp_worst_ff;
   logic [rfs_pkg::FIT_W-1:0]    rsp_avg_ff;
   logic [rfs_pkg::COUNT_W-1:0]  rsp_count_ff;

   // divider
   rfs_pkg::div_ctl_type         div_ctl;
   rfs_pkg::div_sts_type         div_sts;

   logic                         req_accept;
   logic                         not_full;

   rfs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_ctl (div_ctl),
      .div_sts (div_sts)
   );

   // control word fetch
   assign uw         = rfs_pkg::ucode_rom(step_ff);
   assign req_ready  = uw.take;
   assign req_accept = req_valid && uw.take;
   assign rsp_blocked = rsp_valid_ff && !rsp_ready;
   assign rsp_load   = (uw.act == rfs_pkg::ACT_LOAD_RSP) && !rsp_blocked;
   assign not_full   = (count_ff < rfs_pkg::COUNT_W'(rfs_pkg::POP_DEPTH));

   // sequencer condition test
   function automatic logic cond_true(input rfs_pkg::cond_type c,
                                      input logic accept,
                                      input rfs_pkg::op_type op,
                                      input logic nonempty,
                                      input logic walk_hit,
                                      input logic div_busy,
                                      input logic blocked);
      logic r;
      unique case (c)
         rfs_pkg::COND_NEVER:       r = 1'b0;
         rfs_pkg::COND_ALWAYS:      r = 1'b1;
         rfs_pkg::COND_NO_ACCEPT:   r = !accept;
         rfs_pkg::COND_IS_CLEAR:    r = (op == rfs_pkg::OP_CLEAR);
         rfs_pkg::COND_IS_APPEND:   r = (op == rfs_pkg::OP_APPEND);
         rfs_pkg::COND_NO_WALK:     r = !((op == rfs_pkg::OP_SELECT) && nonempty);
         rfs_pkg::COND_NO_HIT:      r = !walk_hit;
         rfs_pkg::COND_DIV_BUSY:    r = div_busy;
         rfs_pkg::COND_RSP_BLOCKED: r = blocked;
         default:                   r = 1'b0;
      endcase
      return r;
   endfunction

   // next step
   always_comb begin
      priority if (cond_true(uw.hold_cond, req_accept, op_ff, (count_ff != '0), hit,
                             div_sts.busy, rsp_blocked)) begin
         step_in = step_ff;
      end else if (cond_true(uw.jump_cond, req_accept, op_ff, (count_ff != '0), hit,
                             div_sts.busy, rsp_blocked)) begin
         step_in = uw.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= rfs_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   // request word latch
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= rfs_pkg::op_type'(req_opcode);
         fit_ff  <= req_fitness_value;
         frac_ff <= req_random_fraction;
      end
   end

   // statistics update
   always_comb begin
      count_in    = count_ff;
      total_in    = total_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      worst_in    = worst_ff;
      avg_in      = avg_ff;
      store_we    = 1'b0;
      unique case (uw.act)
         rfs_pkg::ACT_CLEAR: begin
            count_in    = '0;
            total_in    = '0;
            best_in     = '0;
            best_idx_in = '0;
            worst_in    = rfs_pkg::LOWEST_RESET;
            avg_in      = '0;
         end
         rfs_pkg::ACT_APPEND: begin
            if (not_full) begin
               store_we = 1'b1;
               count_in = count_ff + 1'b1;
               total_in = total_ff + rfs_pkg::TOTAL_W'(fit_ff);
               if (fit_ff > best_ff) begin
                  best_in     = fit_ff;
                  best_idx_in = count_ff[rfs_pkg::ADDR_W-1:0];
               end
               if (fit_ff < worst_ff) begin
                  worst_in = fit_ff;
               end
            end
         end
         rfs_pkg::ACT_AVG_LOAD: begin
            if (!div_sts.busy) begin
               avg_in = div_sts.quotient[rfs_pkg::FIT_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         total_ff    <= '0;
         best_ff     <= '0;
         best_idx_ff <= '0;
         worst_ff    <= rfs_pkg::LOWEST_RESET;
         avg_ff      <= '0;
      end else begin
         count_ff    <= count_in;
         total_ff    <= total_in;
         best_ff     <= best_in;
         best_idx_ff <= best_idx_in;
         worst_ff    <= worst_in;
         avg_ff      <= avg_in;
      end
   end

   // divider kick-off with the updated total and count
   always_comb begin
      div_ctl.start    = (uw.act == rfs_pkg::ACT_DIV_START);
      div_ctl.dividend = total_ff;
      div_ctl.divisor  = count_ff;
   end

   // store: one write port, one registered read port
   assign rd_addr = (uw.act == rfs_pkg::ACT_WALK_STEP) ? (idx_ff + 1'b1) : '0;

   always_ff @(posedge clock) begin
      if (store_we) begin
         store[count_ff[rfs_pkg::ADDR_W-1:0]] <= fit_ff;
      end
      rd_ff <= store[rd_addr];
   end

   // roulette walk: add one stored word a cycle and compare with the slice
   assign product  = frac_ff * total_ff;
   assign sum_next = sum_ff + rfs_pkg::TOTAL_W'(rd_ff);
   assign hit      = ({sum_next, {rfs_pkg::FRAC_W{1'b0}}} >= target_ff);

   always_ff @(posedge clock) begin
      if (uw.act == rfs_pkg::ACT_WALK_INIT) begin
         target_ff <= product;
         sum_ff    <= '0;
         idx_ff    <= '0;
      end else if ((uw.act == rfs_pkg::ACT_WALK_STEP) && !hit) begin
         sum_ff <= sum_next;
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // select result for the current word
   always_ff @(posedge clock) begin
      if (req_accept) begin
         chosen_ff <= '0;
         found_ff  <= 1'b0;
      end else if ((uw.act == rfs_pkg::ACT_WALK_STEP) && hit) begin
         chosen_ff <= idx_ff;
         found_ff  <= 1'b1;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_chosen_ff   <= chosen_ff;
         rsp_found_ff    <= found_ff;
         rsp_total_ff    <= total_ff;
         rsp_best_ff     <= best_ff;
         rsp_best_idx_ff <= best_idx_ff;
         rsp_worst_ff    <= worst_ff;
         rsp_avg_ff      <= avg_ff;
         rsp_count_ff    <= count_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_chosen_index    = rsp_chosen_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_total_fitness   = rsp_total_ff;
   assign rsp_best_fitness    = rsp_best_ff;
   assign rsp_best_index      = rsp_best_idx_ff;
   assign rsp_worst_fitness   = rsp_worst_ff;
   assign rsp_average_fitness = rsp_avg_ff;
   assign rsp_stored_count    = rsp_count_ff;

   // a found entry lies inside a non-empty generation
   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         ({1'b0, rsp_chosen_index} < rsp_stored_count))
      else $error("chosen index outside stored entries");

   // the divider is never running while a new word can be taken
   a_no_take_while_dividing: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_sts.busy)
      else $error("request taken while divider busy");

   // worst never exceeds best once something is stored
   a_worst_le_best: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_stored_count != '0)) |->
         (rsp_worst_fitness <= rsp_best_fitness))
      else $error("worst fitness above best fitness");

   // a walk step always follows the walk set-up or another walk step
   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      (uw.act == rfs_pkg::ACT_WALK_STEP) |->
         ($past(uw.act) == rfs_pkg::ACT_WALK_INIT ||
          $past(uw.act) == rfs_pkg::ACT_WALK_STEP))
      else $error("walk step without set-up");

endmodule

@@ tb/sv/roulette_fitness_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_fitness_checker: response checker for the roulette fitness selector
// Watches the request and response channels, keeps its own copy of the
// generation store and statistics, and compares every response word, field
// by field, with the oldest predicted word.
// ----------------------------------------------------------------------------
module roulette_fitness_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [rfs_pkg::FIT_W-1:0]     req_fitness_value,
   input  logic [rfs_pkg::FRAC_W-1:0]    req_random_fraction,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [rfs_pkg::ADDR_W-1:0]    rsp_chosen_index,
   input  logic                          rsp_found,
   input  logic [rfs_pkg::TOTAL_W-1:0]   rsp_total_fitness,
   input  logic [rfs_pkg::FIT_W-1:0]     rsp_best_fitness,
   input  logic [rfs_pkg::ADDR_W-1:0]    rsp_best_index,
   input  logic [rfs_pkg::FIT_W-1:0]     rsp_worst_fitness,
   input  logic [rfs_pkg::FIT_W-1:0]     rsp_average_fitness,
   input  logic [rfs_pkg::COUNT_W-1:0]   rsp_stored_count,
   output int                            mismatches,
   output int                            pending,
   output int                            checked,
   output int                            hits,
   output int                            full_drops
);

   // one response word as the block should report it
   typedef struct packed {
      logic [rfs_pkg::ADDR_W-1:0]  chosen_index;
      logic                        found;
      logic [rfs_pkg::TOTAL_W-1:0] total_fitness;
      logic [rfs_pkg::FIT_W-1:0]   best_fitness;
      logic [rfs_pkg::ADDR_W-1:0]  best_index;
      logic [rfs_pkg::FIT_W-1:0]   worst_fitness;
      logic [rfs_pkg::FIT_W-1:0]   average_fitness;
      logic [rfs_pkg::COUNT_W-1:0] stored_count;
   } outcome_type;

   // predicted generation state
   logic [rfs_pkg::FIT_W-1:0]   gen_store [rfs_pkg::POP_DEPTH];
   logic [rfs_pkg::COUNT_W-1:0] gen_count;
   logic [rfs_pkg::TOTAL_W-1:0] gen_total;
   logic [rfs_pkg::FIT_W-1:0]   top_value;
   logic [rfs_pkg::ADDR_W-1:0]  top_pos;
   logic [rfs_pkg::FIT_W-1:0]   bottom_value;

   outcome_type awaited_outcomes[$];
   int          mismatch_cnt = 0;
   int          checked_cnt  = 0;
   int          hit_cnt      = 0;
   int          drop_cnt     = 0;

   task automatic clear_generation();
      gen_count    = '0;
      gen_total    = '0;
      top_value    = '0;
      top_pos      = '0;
      bottom_value = rfs_pkg::LOWEST_RESET;
   endtask

   // applies one request word to the predicted state and returns its response
   task automatic roulette_outcome(input rfs_pkg::op_type op,
                                   input logic [rfs_pkg::FIT_W-1:0] fit,
                                   input logic [rfs_pkg::FRAC_W-1:0] frac,
                                   output outcome_type res);
      logic [63:0] slice;
      logic [63:0] running;
      res = '0;
      case (op)
         rfs_pkg::OP_CLEAR: begin
            clear_generation();
         end
         rfs_pkg::OP_APPEND: begin
            if (gen_count < rfs_pkg::POP_DEPTH) begin
               gen_store[gen_count[rfs_pkg::ADDR_W-1:0]] = fit;
               // strictly greater / smaller keeps the first holder on ties
               if (fit > top_value) begin
                  top_value = fit;
                  top_pos   = gen_count[rfs_pkg::ADDR_W-1:0];
               end
               if (fit < bottom_value)
                  bottom_value = fit;
               gen_total = gen_total + rfs_pkg::TOTAL_W'(fit);
               gen_count = gen_count + 1'b1;
            end else begin
               drop_cnt++;
            end
         end
         rfs_pkg::OP_SELECT: begin
            // first entry whose cumulative sum reaches frac * total / 2^16
            if (gen_count != 0) begin
               slice   = 64'(frac);
               slice   = slice * 64'(gen_total);
               running = '0;
               for (int i = 0; i < gen_count; i++) begin
                  if (!res.found) begin
                     running = running + 64'(gen_store[i]);
                     if ((running << 16) >= slice) begin
                        res.found        = 1'b1;
                        res.chosen_index = i[rfs_pkg::ADDR_W-1:0];
                     end
                  end
               end
               if (res.found)
                  hit_cnt++;
            end
         end
         default: begin
         end
      endcase
      res.total_fitness = gen_total;
      res.best_fitness  = top_value;
      res.best_index    = top_pos;
      res.worst_fitness = bottom_value;
      res.stored_count  = gen_count;
      if (gen_count != 0)
         res.average_fitness = rfs_pkg::FIT_W'(gen_total / rfs_pkg::TOTAL_W'(gen_count));
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_cnt++;
      end
   endtask

   // response side first: a word accepted at this edge cannot answer a
   // request accepted at the same edge
   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         clear_generation();
         awaited_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: unexpected response word, expected none, got count %0d total %0d",
                        $time, rsp_stored_count, rsp_total_fitness);
               mismatch_cnt++;
            end else begin
               want = awaited_outcomes.pop_front();
               checked_cnt++;
               check_field("chosen_index", want.chosen_index, rsp_chosen_index);
               check_field("found", want.found, rsp_found);
               check_field("total_fitness", want.total_fitness, rsp_total_fitness);
               check_field("best_fitness", want.best_fitness, rsp_best_fitness);
               check_field("best_index", want.best_index, rsp_best_index);
               check_field("worst_fitness", want.worst_fitness, rsp_worst_fitness);
               check_field("average_fitness", want.average_fitness, rsp_average_fitness);
               check_field("stored_count", want.stored_count, rsp_stored_count);
            end
         end
         if (req_valid && req_ready) begin
            roulette_outcome(rfs_pkg::op_type'(req_opcode), req_fitness_value,
                             req_random_fraction, want);
            awaited_outcomes.insert(awaited_outcomes.size(), want);
         end
      end
      pending    <= awaited_outcomes.size();
      mismatches <= mismatch_cnt;
      checked    <= checked_cnt;
      hits       <= hit_cnt;
      full_drops <= drop_cnt;
   end

endmodule

@@ tb/sv/roulette_fitness_selector_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_fitness_selector_tb: top-level testbench of the fitness selector
// Drives directed and randomised generations (clear, append, select words)
// under three idling mixes, with a long response hold-off, and reports the
// verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module roulette_fitness_selector_tb;

   localparam int WORDS       = 1450;
   localparam int PHASE_WORDS = WORDS / 3;
   localparam int HOLD_AT     = 2 * PHASE_WORDS + 30;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 100;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [1:0]                   req_opcode;
   logic [rfs_pkg::FIT_W-1:0]    req_fitness_value;
   logic [rfs_pkg::FRAC_W-1:0]   req_random_fraction;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [rfs_pkg::ADDR_W-1:0]   rsp_chosen_index;
   logic                         rsp_found;
   logic [rfs_pkg::TOTAL_W-1:0]  rsp_total_fitness;
   logic [rfs_pkg::FIT_W-1:0]    rsp_best_fitness;
   logic [rfs_pkg::ADDR_W-1:0]   rsp_best_index;
   logic [rfs_pkg::FIT_W-1:0]    rsp_worst_fitness;
   logic [rfs_pkg::FIT_W-1:0]    rsp_average_fitness;
   logic [rfs_pkg::COUNT_W-1:0]  rsp_stored_count;

   int mismatches;
   int pending;
   int checked;
   int hits;
   int full_drops;

   int words_sent    = 0;
   int op_sent [4]   = '{0, 0, 0, 0};
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles  = 0;
   int hold_left     = 0;
   int words_seen    = 0;
   bit hold_done     = 1'b0;

   roulette_fitness_selector dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_fitness_value   (req_fitness_value),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_found           (rsp_found),
      .rsp_total_fitness   (rsp_total_fitness),
      .rsp_best_fitness    (rsp_best_fitness),
      .rsp_best_index      (rsp_best_index),
      .rsp_worst_fitness   (rsp_worst_fitness),
      .rsp_average_fitness (rsp_average_fitness),
      .rsp_stored_count    (rsp_stored_count)
   );

   roulette_fitness_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_fitness_value   (req_fitness_value),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_found           (rsp_found),
      .rsp_total_fitness   (rsp_total_fitness),
      .rsp_best_fitness    (rsp_best_fitness),
      .rsp_best_index      (rsp_best_index),
      .rsp_worst_fitness   (rsp_worst_fitness),
      .rsp_average_fitness (rsp_average_fitness),
      .rsp_stored_count    (rsp_stored_count),
      .mismatches          (mismatches),
      .pending             (pending),
      .checked             (checked),
      .hits                (hits),
      .full_drops          (full_drops)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off once well into the run
   always @(posedge clock) begin
      if (req_valid && req_ready)
         words_seen <= words_seen + 1;
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && words_seen >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no word moved for %0d cycles, %0d responses outstanding",
                  $time, stall_cycles, pending);
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // fitness biased towards the extremes and small values
   function automatic logic [rfs_pkg::FIT_W-1:0] pick_fitness();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return rfs_pkg::FIT_W'($urandom_range(15));
         default: return rfs_pkg::FIT_W'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [rfs_pkg::FRAC_W-1:0] pick_fraction();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return rfs_pkg::FRAC_W'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [15:0] pick_any();
      return 16'($urandom_range(65535));
   endfunction

   // offers one request word, idling first at the current rate
   task automatic send_word(input rfs_pkg::op_type op,
                            input logic [rfs_pkg::FIT_W-1:0] fit,
                            input logic [rfs_pkg::FRAC_W-1:0] frac);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_opcode          <= op;
      req_fitness_value   <= fit;
      req_random_fraction <= frac;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      words_sent++;
      op_sent[op]++;
   endtask

   // sender pause until every predicted response has arrived
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // clear, a run of appends with the odd early select, then a few selects
   task automatic run_generation();
      int n;
      int picks;
      send_word(rfs_pkg::OP_CLEAR, pick_any(), pick_any());
      case ($urandom_range(9))
         0:       n = rfs_pkg::POP_DEPTH + $urandom_range(1, 3);
         1, 2:    n = $urandom_range(13, rfs_pkg::POP_DEPTH);
         default: n = $urandom_range(1, 12);
      endcase
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(7) == 0)
            send_word(rfs_pkg::OP_SELECT, pick_any(), pick_fraction());
         send_word(rfs_pkg::OP_APPEND, pick_fitness(), pick_any());
      end
      picks = $urandom_range(1, 6);
      for (int i = 0; i < picks; i++)
         send_word(rfs_pkg::OP_SELECT, pick_any(), pick_fraction());
   endtask

   task automatic run_phase(input int sender_idle, input int receiver_idle,
                            input int quota);
      int stop_at;
      send_idle_pct = sender_idle;
      recv_idle_pct = receiver_idle;
      stop_at       = words_sent + quota;
      while (words_sent < stop_at) begin
         if ($urandom_range(99) < 85)
            run_generation();
         else
            send_word(rfs_pkg::op_type'($urandom_range(3)), pick_any(), pick_any());
         if ($urandom_range(99) < 3)
            wait_quiet();
      end
      wait_quiet();
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_opcode          = rfs_pkg::OP_NOP;
      req_fitness_value   = '0;
      req_random_fraction = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty store straight after reset, and the unused opcode
      send_word(rfs_pkg::OP_SELECT, '0, '0);
      send_word(rfs_pkg::OP_SELECT, '1, '1);
      send_word(rfs_pkg::OP_NOP, '1, '1);
      // all-zero generation picks the first entry
      send_word(rfs_pkg::OP_APPEND, '0, '1);
      send_word(rfs_pkg::OP_APPEND, '0, '0);
      send_word(rfs_pkg::OP_SELECT, '1, '1);
      send_word(rfs_pkg::OP_SELECT, '0, '0);
      // empty after clear
      send_word(rfs_pkg::OP_CLEAR, '1, '1);
      send_word(rfs_pkg::OP_SELECT, '0, 16'd12345);
      // ties on best and worst keep the first holder
      send_word(rfs_pkg::OP_APPEND, 16'd100, '0);
      send_word(rfs_pkg::OP_APPEND, '1, '0);
      send_word(rfs_pkg::OP_APPEND, '0, '0);
      send_word(rfs_pkg::OP_APPEND, '1, '0);
      send_word(rfs_pkg::OP_APPEND, '0, '0);
      send_word(rfs_pkg::OP_APPEND, 16'd1, '0);
      send_word(rfs_pkg::OP_SELECT, '0, '0);
      send_word(rfs_pkg::OP_SELECT, '0, '1);
      send_word(rfs_pkg::OP_SELECT, '0, 16'h8000);
      send_word(rfs_pkg::OP_SELECT, '0, 16'd1);
      send_word(rfs_pkg::OP_NOP, '0, '0);
      send_word(rfs_pkg::OP_CLEAR, '0, '0);
      send_word(rfs_pkg::OP_APPEND, '1, '1);
      send_word(rfs_pkg::OP_SELECT, '1, '1);
      wait_quiet();

      run_phase(20, 69, PHASE_WORDS);
      run_phase(69, 20, PHASE_WORDS);
      run_phase(0, 0, WORDS - 2 * PHASE_WORDS);

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run covered %0d words: %0d clears, %0d appends, %0d selects, %0d unused",
               words_sent, op_sent[rfs_pkg::OP_CLEAR], op_sent[rfs_pkg::OP_APPEND],
               op_sent[rfs_pkg::OP_SELECT], op_sent[rfs_pkg::OP_NOP]);
      $display("%0d responses checked, %0d selects hit an entry, %0d appends hit a full store",
               checked, hits, full_drops);
      if (mismatches == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
src/rfs_pkg.sv
src/rfs_divider.sv
src/roulette_fitness_selector.sv
tb/sv/roulette_fitness_checker.sv
tb/sv/roulette_fitness_selector_tb.sv
